@@ hw/rtl/sbbr_pkg.sv @@
// Shared types and constants for the serial bus byte receiver.
package sbbr_pkg;

    // Processor port request kinds carried on the input tuser.
    typedef enum logic [1:0] {
        REQ_DIR   = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    // Bus protocol mode of the listener.
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_CMD    = 3'd1,
        MODE_LISTEN = 3'd2,
        MODE_TALK   = 3'd3,
        MODE_DATIN  = 3'd4,
        MODE_DATOUT = 3'd5
    } mode_t;

    // Progress of the bit currently on the bus.
    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_BIT  = 2'd2,
        PH_BITB = 2'd3
    } phase_t;

    // Decoded event reported with every result.
    typedef enum logic [2:0] {
        EVT_NONE        = 3'd0,
        EVT_TALK        = 3'd1,
        EVT_LISTEN      = 3'd2,
        EVT_UNLISTEN    = 3'd3,
        EVT_UNTALK      = 3'd4,
        EVT_TALK_SEC    = 3'd5,
        EVT_LISTEN_SEC  = 3'd6,
        EVT_DATA        = 3'd7
    } evt_t;

    // Command byte high nibbles and the broadcast device number.
    localparam logic [3:0] CMD_TALK     = 4'h4;
    localparam logic [3:0] CMD_LISTEN   = 4'h2;
    localparam logic [3:0] CMD_UNLISTEN = 4'h3;
    localparam logic [3:0] CMD_UNTALK   = 4'h5;
    localparam logic [3:0] DEV_ALL      = 4'hf;

    // Only legal value for the port direction register.
    localparam logic [7:0] DIR_EXPECTED = 8'h0f;

    // Bits per bus byte.
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Reset value of the acknowledge read delay.
    localparam logic [3:0] ACK_DELAY_RESET = 4'd5;

    // One result transaction.
    typedef struct packed {
        logic [7:0] event_byte;
        logic [3:0] event_device;
        evt_t       event_kind;
        logic       direction_fault;
        logic [7:0] port_result;
    } result_t;

endpackage

@@ hw/rtl/sbbr_core.sv @@
// Bus state tracking, byte decode and port result logic for one request.
module sbbr_core
    import sbbr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  req_t       req,
    input  logic [7:0] port_value,
    input  logic [3:0] ack_delay,
    output result_t    result
);

    mode_t      mode_reg, mode_next;
    phase_t     phase_reg, phase_next;
    logic       dlo_reg, dlo_next;
    logic [7:0] shift_reg, shift_next;
    logic [3:0] bit_cnt_reg, bit_cnt_next;
    logic       ack_reg, ack_next;
    logic [3:0] read_cnt_reg, read_cnt_next;
    logic       release_reg, release_next;

    logic       line_dat;
    logic       line_clk;
    logic       line_atn;
    logic [3:0] cmd_nib;
    logic [3:0] dev_nib;
    logic [3:0] read_cnt_inc;
    logic       byte_done;

    // Line levels arrive inverted in the written byte.
    assign line_dat     = ~port_value[0];
    assign line_clk     = ~port_value[1];
    assign line_atn     = ~port_value[2];
    assign cmd_nib      = shift_reg[7:4];
    assign dev_nib      = shift_reg[3:0];
    assign read_cnt_inc = read_cnt_reg + 4'd1;
    assign byte_done    = (bit_cnt_reg == BITS_PER_BYTE);

    // Next state and result for the request at the input.
    always_comb begin
        mode_next     = mode_reg;
        phase_next    = phase_reg;
        dlo_next      = dlo_reg;
        shift_next    = shift_reg;
        bit_cnt_next  = bit_cnt_reg;
        ack_next      = ack_reg;
        read_cnt_next = read_cnt_reg;
        release_next  = release_reg;
        result        = '0;

        unique case (req)
            REQ_DIR: begin
                result.port_result     = port_value;
                result.direction_fault = (port_value != DIR_EXPECTED);
            end
            REQ_WRITE: begin
                ack_next = 1'b0;
                if (mode_reg != MODE_CMD && !line_atn) begin
                    // Attention pulled: enter command mode.
                    mode_next  = MODE_CMD;
                    phase_next = PH_NONE;
                    dlo_next   = 1'b0;
                end else if (mode_reg != MODE_IDLE && phase_reg == PH_NONE && line_clk) begin
                    // Talker starts a bit; answer on DATA.
                    ack_next   = 1'b1;
                    phase_next = PH_BIT;
                    dlo_next   = 1'b1;
                end else if (mode_reg != MODE_IDLE && phase_reg == PH_BIT) begin
                    if (line_clk) begin
                        phase_next   = PH_BITB;
                        shift_next   = {line_dat, shift_reg[7:1]};
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                    end
                end else if (mode_reg != MODE_IDLE && phase_reg == PH_BITB) begin
                    if (!line_clk && byte_done) begin
                        dlo_next = 1'b0;
                    end
                    if (line_dat) begin
                        if (byte_done) begin
                            bit_cnt_next = 4'd0;
                            dlo_next     = 1'b0;
                            phase_next   = PH_NONE;
                            shift_next   = 8'd0;
                            // Decode the finished byte against the current mode.
                            unique case (mode_reg)
                                MODE_CMD: begin
                                    if (cmd_nib == CMD_TALK) begin
                                        result.event_kind   = EVT_TALK;
                                        result.event_device = dev_nib;
                                        mode_next           = MODE_TALK;
                                    end else if (cmd_nib == CMD_LISTEN) begin
                                        result.event_kind   = EVT_LISTEN;
                                        result.event_device = dev_nib;
                                        mode_next           = MODE_LISTEN;
                                    end else if (cmd_nib == CMD_UNLISTEN) begin
                                        if (dev_nib == DEV_ALL) begin
                                            result.event_kind   = EVT_UNLISTEN;
                                            result.event_device = dev_nib;
                                        end
                                        mode_next = MODE_IDLE;
                                    end else if (cmd_nib == CMD_UNTALK) begin
                                        if (dev_nib == DEV_ALL) begin
                                            result.event_kind   = EVT_UNTALK;
                                            result.event_device = dev_nib;
                                        end
                                        mode_next = MODE_IDLE;
                                    end
                                end
                                MODE_TALK: begin
                                    result.event_kind = EVT_TALK_SEC;
                                    result.event_byte = shift_reg;
                                    mode_next         = MODE_DATIN;
                                end
                                MODE_LISTEN: begin
                                    result.event_kind = EVT_LISTEN_SEC;
                                    result.event_byte = shift_reg;
                                    mode_next         = MODE_DATOUT;
                                end
                                MODE_DATOUT: begin
                                    result.event_kind = EVT_DATA;
                                    result.event_byte = shift_reg;
                                end
                                default: begin
                                end
                            endcase
                        end else begin
                            phase_next = PH_BIT;
                            dlo_next   = 1'b1;
                        end
                    end
                end
                // DATA output on bit 7, clock output and tape bits forced.
                result.port_result = {dlo_next, 3'b000, 1'b1, port_value[2:0]};
            end
            REQ_READ: begin
                result.port_result = port_value;
                if (release_reg) begin
                    result.port_result[7] = 1'b1;
                    release_next          = 1'b0;
                    read_cnt_next         = 4'd0;
                end else if (ack_reg) begin
                    read_cnt_next = read_cnt_inc;
                    if (read_cnt_inc >= ack_delay) begin
                        result.port_result[7] = 1'b0;
                        ack_next              = 1'b0;
                        release_next          = 1'b1;
                        read_cnt_next         = 4'd0;
                    end
                end else begin
                    read_cnt_next = 4'd0;
                end
            end
            REQ_NONE: begin
            end
            default: begin
            end
        endcase
    end

    // State registers advance once per accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            phase_reg    <= PH_NONE;
            dlo_reg      <= 1'b0;
            shift_reg    <= 8'd0;
            bit_cnt_reg  <= 4'd0;
            ack_reg      <= 1'b0;
            read_cnt_reg <= 4'd0;
            release_reg  <= 1'b0;
        end else if (in_fire) begin
            mode_reg     <= mode_next;
            phase_reg    <= phase_next;
            dlo_reg      <= dlo_next;
            shift_reg    <= shift_next;
            bit_cnt_reg  <= bit_cnt_next;
            ack_reg      <= ack_next;
            read_cnt_reg <= read_cnt_next;
            release_reg  <= release_next;
        end
    end

    // The DATA output is only driven while a bit is in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        dlo_reg |-> (phase_reg != PH_NONE))
        else $error("DATA driven with no bit in progress");

    // An idle bus has no bit in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_IDLE) |-> (phase_reg == PH_NONE && !dlo_reg))
        else $error("bit activity while idle");

    // Port reads and direction writes never move the bus mode.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && req != REQ_WRITE) |=> $stable(mode_reg))
        else $error("bus mode changed without a data write");

endmodule

@@ hw/rtl/sbbr_out_buf.sv @@
// Two-entry output register with skid stage for result transactions.
module sbbr_out_buf
    import sbbr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_fire,
    input  result_t in_result,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;
    logic    out_take;

    assign in_ready   = ~skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_result = out_data_reg;
    assign out_take   = out_valid_reg & out_ready;

    // Valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (in_fire) begin
            if (out_valid_reg && !out_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (out_take) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_take) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (in_fire) begin
            if (out_valid_reg && !out_ready) begin
                skid_data_reg <= in_result;
            end else begin
                out_data_reg <= in_result;
            end
        end
    end

    // The skid stage only fills behind a waiting output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full with empty output");

    // A new result behind a stalled output lands in the skid stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("result lost behind stalled output");

    // Draining the skid stage keeps the output occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid stage drain dropped a result");

endmodule

@@ hw/rtl/serial_bus_byte_receiver.sv @@
// Top level of the serial bus byte receiver.
//
// Each input transaction is one processor access to the emulated port:
// s_tuser selects a direction write, a data port write or a data port read,
// and s_tdata carries the byte written or the raw byte read. Every input
// transaction yields exactly one result transaction on the m_ side with the
// final port value, the direction fault flag and any decoded bus event
// (talk, listen, unlisten, untalk, secondary address or data byte).
// The result is registered into the output register, or into the skid
// stage when the output is stalled; one transaction is accepted every cycle
// while s_tready is high. The skid stage holds one extra result, so
// s_tready drops only when the output is stalled with two results waiting.
// The acknowledge read delay is written through cfg_wr_en and cfg_wr_data;
// the user must write it only while the block is idle, which the block
// does not enforce. Synchronous reset returns the bus to idle, clears all
// counters, empties both result registers, and sets the read delay to five.
module serial_bus_byte_receiver
    import sbbr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] port_value
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] port_result, [8] direction_fault,
                                   // [12:9] event_device, [20:13] event_byte, rest zero
    output logic [2:0]  m_tuser    // [2:0] event_kind
);

    logic [3:0] ack_delay_reg;
    logic       in_fire;
    result_t    core_result;
    result_t    out_result;

    assign in_fire = s_tvalid & s_tready;

    // Acknowledge read delay register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_delay_reg <= ACK_DELAY_RESET;
        end else if (cfg_wr_en) begin
            ack_delay_reg <= cfg_wr_data;
        end
    end

    sbbr_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .req        (req_t'(s_tuser)),
        .port_value (s_tdata),
        .ack_delay  (ack_delay_reg),
        .result     (core_result)
    );

    sbbr_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .in_result  (core_result),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    // Pack the result transaction onto the master side.
    assign m_tdata = {3'b000, out_result.event_byte, out_result.event_device,
                      out_result.direction_fault, out_result.port_result};
    assign m_tuser = out_result.event_kind;

endmodule
